FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/pps_pkg.sv
// Package for the preemptive priority scheduler.
// Holds table sizes, field widths and the sequencer state type; no dependencies.
`default_nettype none

package pps_pkg;

  localparam int MAX_TASKS = 16;
  localparam int TIME_BITS = 16;
  localparam int PRIO_BITS = 8;
  localparam int SLOT_W    = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/preemptive_priority_scheduler.sv
// Preemptive priority scheduler: in a single module, the task table, the scan sequencer
// and the result register. It depends on pps_pkg and on assert_macros.svh.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one request per transaction:
//   in_mode = 0 adds a task to the next free slot, and in_mode = 1 advances time
//   by one tick. The result channel (out_valid / out_stall) returns exactly one
//   transaction for each request.
//   Add: the result is registered from the add state once the output register is free.
//   Tick: one compare unit walks all 16 slots, one slot per cycle, to find the
//   eligible task with the smallest priority value. The update state then computes the
//   turnaround time, and the done state computes the waiting time and registers the result.
//   in_stall is high while a request is in progress, so the block takes no new
//   request until the last one has registered its result. The next request is
//   accepted while an earlier result still waits in the output register.
//   When the receiver stalls, the result holds on the output. A finished request
//   waits in its last state, without changing the table, until the register frees.
//   Reset (rst_n low, synchronous) sets the clock to zero and empties the table.
//   No clearing pass is needed.
`default_nettype none

`include "assert_macros.svh"

module preemptive_priority_scheduler (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Request channel.
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_mode,
  input  wire logic [pps_pkg::TIME_BITS-1:0]  in_arrival_time,
  input  wire logic [pps_pkg::TIME_BITS-1:0]  in_burst_length,
  input  wire logic [pps_pkg::PRIO_BITS-1:0]  in_task_priority,
  // Result channel.
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_accepted,
  output logic [pps_pkg::SLOT_W-1:0]          out_slot_id,
  output logic                                out_idle,
  output logic                                out_completed,
  output logic [pps_pkg::TIME_BITS-1:0]       out_start_tick,
  output logic [pps_pkg::TIME_BITS-1:0]       out_finish_tick,
  output logic [pps_pkg::TIME_BITS-1:0]       out_waiting_ticks,
  output logic [pps_pkg::TIME_BITS-1:0]       out_turnaround_ticks,
  output logic                                out_all_finished
);

  localparam int TB = pps_pkg::TIME_BITS;
  localparam int PB = pps_pkg::PRIO_BITS;
  localparam int SW = pps_pkg::SLOT_W;
  localparam int CW = pps_pkg::CNT_W;
  localparam int NT = pps_pkg::MAX_TASKS;

  // Sequencer and global state.
  pps_pkg::state_t state_r, state_nxt;
  logic [TB-1:0]   clock_r;
  logic [CW-1:0]   slots_used_r;

  // Captured add request.
  logic [TB-1:0]   arr_in_r;
  logic [TB-1:0]   burst_in_r;
  logic [PB-1:0]   prio_in_r;

  // Task table.
  logic [TB-1:0]   arrival_mem_r [NT];
  logic [TB-1:0]   burst_mem_r   [NT];
  logic [TB-1:0]   remain_mem_r  [NT];
  logic [PB-1:0]   prio_mem_r    [NT];
  logic [TB-1:0]   start_mem_r   [NT];
  logic [NT-1:0]   started_r, started_nxt;
  logic [NT-1:0]   live_r, live_nxt;

  // Scan and update working registers.
  logic [SW-1:0]   idx_r;
  logic            found_r;
  logic [SW-1:0]   best_r;
  logic [PB-1:0]   best_prio_r;
  logic [TB-1:0]   tat_r;
  logic [TB-1:0]   rem_dec_r;

  // Result register.
  logic            out_valid_r;
  logic            out_accepted_r;
  logic [SW-1:0]   out_slot_id_r;
  logic            out_idle_r;
  logic            out_completed_r;
  logic [TB-1:0]   out_start_tick_r;
  logic [TB-1:0]   out_finish_tick_r;
  logic [TB-1:0]   out_waiting_ticks_r;
  logic [TB-1:0]   out_turnaround_ticks_r;
  logic            out_all_finished_r;

  // Control decoded from the state.
  logic            in_fire;
  logic            out_free;
  logic            res_fire;
  logic            add_fire;
  logic            tick_fire;
  logic            scan_last;
  logic            table_full;

  // Datapath signals.
  logic [SW-1:0]   rd_addr;
  logic [SW-1:0]   add_slot;
  logic            elig;
  logic [TB-1:0]   sub_a, sub_b, sub_res;
  logic [TB-1:0]   clock_inc;
  logic            done_now;
  logic [TB-1:0]   add_burst;

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pps_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_mode ? pps_pkg::ST_SCAN : pps_pkg::ST_ADD;
        end
      end
      pps_pkg::ST_ADD: begin
        if (out_free) begin
          state_nxt = pps_pkg::ST_IDLE;
        end
      end
      pps_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_nxt = pps_pkg::ST_UPDATE;
        end
      end
      pps_pkg::ST_UPDATE: begin
        state_nxt = pps_pkg::ST_DONE;
      end
      pps_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = pps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pps_pkg::ST_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall  = 1'b1;
    res_fire  = 1'b0;
    add_fire  = 1'b0;
    tick_fire = 1'b0;
    case (state_r)
      pps_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      pps_pkg::ST_ADD: begin
        res_fire = out_free;
        add_fire = out_free;
      end
      pps_pkg::ST_DONE: begin
        res_fire  = out_free;
        tick_fire = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign in_fire    = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign scan_last  = (idx_r == SW'(NT - 1));
  assign table_full = (slots_used_r >= CW'(NT));
  assign add_slot   = slots_used_r[SW-1:0];
  assign add_burst  = (burst_in_r == '0) ? TB'(1) : burst_in_r;
  assign clock_inc  = clock_r + TB'(1);

  // The table has a single read address: the scanned slot, or afterwards the chosen one.
  assign rd_addr = (state_r == pps_pkg::ST_SCAN) ? idx_r : best_r;
  assign elig    = live_r[rd_addr] && (arrival_mem_r[rd_addr] <= clock_r);

  // A shared subtractor computes turnaround first, then waiting time.
  always_comb begin
    if (state_r == pps_pkg::ST_UPDATE) begin
      sub_a = clock_inc;
      sub_b = arrival_mem_r[rd_addr];
    end else begin
      sub_a = tat_r;
      sub_b = burst_mem_r[rd_addr];
    end
  end
  assign sub_res  = sub_a - sub_b;
  assign done_now = found_r && (rem_dec_r == '0);

  // Next values of the per-slot flags.
  always_comb begin
    live_nxt    = live_r;
    started_nxt = started_r;
    if (add_fire && !table_full) begin
      live_nxt[add_slot]    = 1'b1;
      started_nxt[add_slot] = 1'b0;
    end
    if (tick_fire && found_r) begin
      started_nxt[best_r] = 1'b1;
      if (rem_dec_r == '0) begin
        live_nxt[best_r] = 1'b0;
      end
    end
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pps_pkg::ST_IDLE;
      clock_r      <= '0;
      slots_used_r <= '0;
      live_r       <= '0;
      started_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      live_r    <= live_nxt;
      started_r <= started_nxt;
      if (add_fire && !table_full) begin
        slots_used_r <= slots_used_r + CW'(1);
      end
      if (tick_fire) begin
        clock_r <= clock_inc;
      end
      if (res_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the request, and run the scan over the slots.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      arr_in_r    <= in_arrival_time;
      burst_in_r  <= in_burst_length;
      prio_in_r   <= in_task_priority;
      idx_r       <= '0;
      found_r     <= 1'b0;
      best_r      <= '0;
      best_prio_r <= '0;
    end else if (state_r == pps_pkg::ST_SCAN) begin
      idx_r <= idx_r + SW'(1);
      if (elig && (!found_r || (prio_mem_r[rd_addr] < best_prio_r))) begin
        found_r     <= 1'b1;
        best_r      <= idx_r;
        best_prio_r <= prio_mem_r[rd_addr];
      end
    end
    if (state_r == pps_pkg::ST_UPDATE) begin
      tat_r     <= sub_res;
      rem_dec_r <= remain_mem_r[rd_addr] - TB'(1);
    end
  end

  // Table writes: a new task on an add, or the running task on a tick.
  always_ff @(posedge clk) begin
    if (add_fire && !table_full) begin
      arrival_mem_r[add_slot] <= arr_in_r;
      burst_mem_r[add_slot]   <= add_burst;
      remain_mem_r[add_slot]  <= add_burst;
      prio_mem_r[add_slot]    <= prio_in_r;
      start_mem_r[add_slot]   <= '0;
    end
    if (tick_fire && found_r) begin
      remain_mem_r[best_r] <= rem_dec_r;
      if (!started_r[best_r]) begin
        start_mem_r[best_r] <= clock_r;
      end
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_all_finished_r <= ~|live_nxt;
      if (add_fire) begin
        out_accepted_r         <= !table_full;
        out_slot_id_r          <= table_full ? '0 : add_slot;
        out_idle_r             <= 1'b0;
        out_completed_r        <= 1'b0;
        out_start_tick_r       <= '0;
        out_finish_tick_r      <= '0;
        out_waiting_ticks_r    <= '0;
        out_turnaround_ticks_r <= '0;
      end else begin
        out_accepted_r  <= 1'b0;
        out_slot_id_r   <= found_r ? best_r : '0;
        out_idle_r      <= !found_r;
        out_completed_r <= done_now;
        if (done_now) begin
          out_start_tick_r       <= started_r[best_r] ? start_mem_r[best_r] : clock_r;
          out_finish_tick_r      <= clock_inc;
          out_waiting_ticks_r    <= sub_res;
          out_turnaround_ticks_r <= tat_r;
        end else begin
          out_start_tick_r       <= '0;
          out_finish_tick_r      <= '0;
          out_waiting_ticks_r    <= '0;
          out_turnaround_ticks_r <= '0;
        end
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_accepted         = out_accepted_r;
  assign out_slot_id          = out_slot_id_r;
  assign out_idle             = out_idle_r;
  assign out_completed        = out_completed_r;
  assign out_start_tick       = out_start_tick_r;
  assign out_finish_tick      = out_finish_tick_r;
  assign out_waiting_ticks    = out_waiting_ticks_r;
  assign out_turnaround_ticks = out_turnaround_ticks_r;
  assign out_all_finished     = out_all_finished_r;

  // Checks on the table bookkeeping and the result encoding.
  `ASSERT_ALWAYS(a_used_bound, slots_used_r <= CW'(NT), "slot count beyond table size")
  `ASSERT_ALWAYS(a_live_in_used, (live_r >> slots_used_r) == '0, "live slot above fill")
  `ASSERT_NEXT(a_clock_step, tick_fire, clock_r == $past(clock_r) + TB'(1), "tick clock step")
  `ASSERT_IMPLIES(a_done_enc, out_valid_r && out_completed_r,
                  !out_idle_r && !out_accepted_r, "completion flags conflict")

endmodule

`default_nettype wire

FILE: test/sched_checker.sv
// Request codes shared by the testbench, plus the scoreboard for the priority scheduler.
// Depends on pps_pkg for table sizes and field widths.
`timescale 1ns / 100ps

package sched_tb_pkg;

  // Request kinds carried on in_mode.
  typedef enum logic {
    MODE_ADD  = 1'b0,
    MODE_TICK = 1'b1
  } sched_mode_t;

endpackage

module sched_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic                           in_stall,
  input  wire logic                           in_mode,
  input  wire logic [pps_pkg::TIME_BITS-1:0]  in_arrival_time,
  input  wire logic [pps_pkg::TIME_BITS-1:0]  in_burst_length,
  input  wire logic [pps_pkg::PRIO_BITS-1:0]  in_task_priority,
  input  wire logic                           out_valid,
  input  wire logic                           out_stall,
  input  wire logic                           out_accepted,
  input  wire logic [pps_pkg::SLOT_W-1:0]     out_slot_id,
  input  wire logic                           out_idle,
  input  wire logic                           out_completed,
  input  wire logic [pps_pkg::TIME_BITS-1:0]  out_start_tick,
  input  wire logic [pps_pkg::TIME_BITS-1:0]  out_finish_tick,
  input  wire logic [pps_pkg::TIME_BITS-1:0]  out_waiting_ticks,
  input  wire logic [pps_pkg::TIME_BITS-1:0]  out_turnaround_ticks,
  input  wire logic                           out_all_finished,
  output int                                  fail_count,
  output int                                  pending
);
  localparam int MAX_TASKS = pps_pkg::MAX_TASKS;
  localparam int TIME_BITS = pps_pkg::TIME_BITS;
  localparam int PRIO_BITS = pps_pkg::PRIO_BITS;
  localparam int SLOT_W    = pps_pkg::SLOT_W;

  // One result transaction, fields in port order.
  typedef struct packed {
    logic                 accepted;
    logic [SLOT_W-1:0]    slot_id;
    logic                 idle;
    logic                 completed;
    logic [TIME_BITS-1:0] start_tick;
    logic [TIME_BITS-1:0] finish_tick;
    logic [TIME_BITS-1:0] waiting_ticks;
    logic [TIME_BITS-1:0] turnaround_ticks;
    logic                 all_finished;
  } sched_result_t;

  // Shadow copy of the scheduler's clock and job table.
  logic [TIME_BITS-1:0] sched_clock;
  int unsigned          jobs_stored;
  logic [TIME_BITS-1:0] job_arrival   [MAX_TASKS];
  logic [TIME_BITS-1:0] job_burst     [MAX_TASKS];
  logic [TIME_BITS-1:0] job_left      [MAX_TASKS];
  logic [TIME_BITS-1:0] job_first_run [MAX_TASKS];
  logic [PRIO_BITS-1:0] job_prio      [MAX_TASKS];
  logic                 job_started   [MAX_TASKS];
  logic                 job_live      [MAX_TASKS];

  sched_result_t expected_results[$];

  // Applies one request to the shadow table and returns the result it should produce.
  function automatic sched_result_t schedule_step(input logic mode,
                                                  input logic [TIME_BITS-1:0] arrival,
                                                  input logic [TIME_BITS-1:0] burst,
                                                  input logic [PRIO_BITS-1:0] prio);
    sched_result_t r;
    int unsigned   s;
    int unsigned   best;
    int unsigned   k;
    bit            found;
    logic [TIME_BITS-1:0] tat;
    r = '0;
    if (mode == sched_tb_pkg::MODE_ADD) begin
      // Slots fill in order and are never given back.
      if (jobs_stored < MAX_TASKS) begin
        s = jobs_stored;
        job_arrival[s]   = arrival;
        job_burst[s]     = (burst == '0) ? TIME_BITS'(1) : burst;
        job_left[s]      = job_burst[s];
        job_prio[s]      = prio;
        job_first_run[s] = '0;
        job_started[s]   = 1'b0;
        job_live[s]      = 1'b1;
        jobs_stored      = s + 1;
        r.accepted       = 1'b1;
        r.slot_id        = SLOT_W'(s);
      end
    end else begin
      // Pick the arrived live job with the smallest priority value, lowest slot on ties.
      found = 1'b0;
      best  = 0;
      for (k = 0; k < jobs_stored; k++) begin
        if (job_live[k] && job_arrival[k] <= sched_clock) begin
          if (!found || job_prio[k] < job_prio[best]) begin
            best  = k;
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        r.idle = 1'b1;
        sched_clock = sched_clock + 1'b1;
      end else begin
        r.slot_id = SLOT_W'(best);
        if (!job_started[best]) begin
          job_started[best]   = 1'b1;
          job_first_run[best] = sched_clock;
        end
        if (job_left[best] != '0) job_left[best] = job_left[best] - 1'b1;
        sched_clock = sched_clock + 1'b1;
        // The job finishes on the tick that runs its last unit of work.
        if (job_left[best] == '0) begin
          tat                = sched_clock - job_arrival[best];
          job_live[best]     = 1'b0;
          r.completed        = 1'b1;
          r.start_tick       = job_first_run[best];
          r.finish_tick      = sched_clock;
          r.turnaround_ticks = tat;
          r.waiting_ticks    = tat - job_burst[best];
        end
      end
    end
    r.all_finished = 1'b1;
    for (k = 0; k < jobs_stored; k++) begin
      if (job_live[k]) r.all_finished = 1'b0;
    end
    return r;
  endfunction

  function automatic string show_result(input sched_result_t r);
    return $sformatf("acc=%0d slot=%0d idle=%0d done=%0d start=%0d finish=%0d wait=%0d tat=%0d all=%0d",
                     r.accepted, r.slot_id, r.idle, r.completed, r.start_tick,
                     r.finish_tick, r.waiting_ticks, r.turnaround_ticks, r.all_finished);
  endfunction

  // Compare each result transaction first, then queue the prediction for a new request.
  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t want;
    if (!rst_n) begin
      sched_clock = '0;
      jobs_stored = 0;
      for (int k = 0; k < MAX_TASKS; k++) begin
        job_arrival[k]   = '0;
        job_burst[k]     = '0;
        job_left[k]      = '0;
        job_first_run[k] = '0;
        job_prio[k]      = '0;
        job_started[k]   = 1'b0;
        job_live[k]      = 1'b0;
      end
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_accepted, out_slot_id, out_idle, out_completed, out_start_tick,
               out_finish_tick, out_waiting_ticks, out_turnaround_ticks, out_all_finished};
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result transaction: %s", $realtime, show_result(got));
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                       $realtime, show_result(want), show_result(got));
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(schedule_step(in_mode, in_arrival_time,
                                                 in_burst_length, in_task_priority));
    end
    pending = expected_results.size();
  end

endmodule

FILE: test/tb.sv
// Top of the scheduler testbench: clock, reset, request stimulus and the verdict.
// Depends on pps_pkg, the scheduler RTL and sched_checker.sv.
`timescale 1ns / 100ps

module tb;
  localparam int TIME_BITS = pps_pkg::TIME_BITS;
  localparam int PRIO_BITS = pps_pkg::PRIO_BITS;
  localparam int SLOT_W    = pps_pkg::SLOT_W;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int RANDOM_ITEMS = 300;
  // Ticks sent back to back at the end of the run.
  localparam int TAIL_TICKS   = 80;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_mode = 1'b0;
  logic [TIME_BITS-1:0] in_arrival_time = '0;
  logic [TIME_BITS-1:0] in_burst_length = '0;
  logic [PRIO_BITS-1:0] in_task_priority = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_accepted;
  logic [SLOT_W-1:0]    out_slot_id;
  logic                 out_idle;
  logic                 out_completed;
  logic [TIME_BITS-1:0] out_start_tick;
  logic [TIME_BITS-1:0] out_finish_tick;
  logic [TIME_BITS-1:0] out_waiting_ticks;
  logic [TIME_BITS-1:0] out_turnaround_ticks;
  logic                 out_all_finished;

  int                   fail_count;
  int                   pending;
  int                   cycle_count = 0;
  bit                   gaps_on = 1'b0;
  bit                   stalls_on = 1'b0;
  int                   stall_left = 0;
  logic [TIME_BITS-1:0] ticks_sent = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  preemptive_priority_scheduler u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_mode              (in_mode),
    .in_arrival_time      (in_arrival_time),
    .in_burst_length      (in_burst_length),
    .in_task_priority     (in_task_priority),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_accepted         (out_accepted),
    .out_slot_id          (out_slot_id),
    .out_idle             (out_idle),
    .out_completed        (out_completed),
    .out_start_tick       (out_start_tick),
    .out_finish_tick      (out_finish_tick),
    .out_waiting_ticks    (out_waiting_ticks),
    .out_turnaround_ticks (out_turnaround_ticks),
    .out_all_finished     (out_all_finished)
  );

  sched_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_mode              (in_mode),
    .in_arrival_time      (in_arrival_time),
    .in_burst_length      (in_burst_length),
    .in_task_priority     (in_task_priority),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_accepted         (out_accepted),
    .out_slot_id          (out_slot_id),
    .out_idle             (out_idle),
    .out_completed        (out_completed),
    .out_start_tick       (out_start_tick),
    .out_finish_tick      (out_finish_tick),
    .out_waiting_ticks    (out_waiting_ticks),
    .out_turnaround_ticks (out_turnaround_ticks),
    .out_all_finished     (out_all_finished),
    .fail_count           (fail_count),
    .pending              (pending)
  );

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("preemptive_priority_scheduler verification failed");
      $finish;
    end
  end

  // Receiver back-pressure in bursts of random length.
  always @(negedge clk) begin
    if (!stalls_on) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Presents one request and holds it until the block takes the transaction.
  task automatic send_req(input sched_tb_pkg::sched_mode_t mode,
                          input logic [TIME_BITS-1:0] arrival,
                          input logic [TIME_BITS-1:0] burst,
                          input logic [PRIO_BITS-1:0] prio);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= mode;
    in_arrival_time  <= arrival;
    in_burst_length  <= burst;
    in_task_priority <= prio;
    do @(posedge clk); while (in_stall);
    if (mode == sched_tb_pkg::MODE_TICK) ticks_sent = ticks_sent + 1'b1;
  endtask

  // Ticks ignore the job fields, so they carry random values.
  task automatic send_tick();
    send_req(sched_tb_pkg::MODE_TICK, TIME_BITS'($urandom), TIME_BITS'($urandom),
             PRIO_BITS'($urandom));
  endtask

  // The sender goes quiet until every outstanding result has come back.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
  endtask

  initial begin
    int unsigned          roll;
    logic [TIME_BITS-1:0] arrival;
    logic [TIME_BITS-1:0] burst;
    logic [PRIO_BITS-1:0] prio;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;

    // A tick on an empty table is idle and everything counts as finished.
    send_tick();
    // A zero burst is stored as one; two equal priorities tie on slot number.
    send_req(sched_tb_pkg::MODE_ADD, 16'd0, 16'd0, 8'd255);
    send_req(sched_tb_pkg::MODE_ADD, 16'd3, 16'd3, 8'd0);
    send_req(sched_tb_pkg::MODE_ADD, 16'd3, 16'd2, 8'd0);
    send_tick();
    // Jobs are stored but none has arrived yet.
    send_tick();
    // A later arrival with a smaller priority value preempts the running job.
    send_req(sched_tb_pkg::MODE_ADD, 16'd0, 16'd4, 8'd100);
    send_req(sched_tb_pkg::MODE_ADD, 16'd9, 16'd2, 8'd50);
    repeat (11) send_tick();
    // Two jobs whose arrival lies at the top of the clock range, and a
    // maximum-length job that stays live at the lowest priority.
    send_req(sched_tb_pkg::MODE_ADD, 16'hFFFF, 16'd1, 8'd0);
    send_req(sched_tb_pkg::MODE_ADD, 16'hFFFD, 16'd3, 8'd1);
    send_req(sched_tb_pkg::MODE_ADD, ticks_sent, 16'hFFFF, 8'd255);
    wait_for_results();

    // Mostly ticks with adds mixed in until the table fills; later adds are rejected.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      gaps_on   = (i % 100) < 70;
      stalls_on = (i % 100) < 70;
      if ($urandom_range(0, 9) == 0) begin
        arrival = ($urandom_range(0, 9) < 7) ? TIME_BITS'(ticks_sent + $urandom_range(0, 24))
                                             : TIME_BITS'($urandom_range(0, 65535));
        roll = $urandom_range(0, 9);
        if (roll == 0) burst = '0;
        else if (roll < 3) burst = TIME_BITS'($urandom_range(9, 64));
        else burst = TIME_BITS'($urandom_range(1, 8));
        prio = ($urandom_range(0, 4) < 2) ? PRIO_BITS'($urandom_range(0, 3))
                                          : PRIO_BITS'($urandom_range(0, 255));
        send_req(sched_tb_pkg::MODE_ADD, arrival, burst, prio);
      end else begin
        send_tick();
      end
    end
    wait_for_results();

    // Closing stretch at full rate.
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    repeat (TAIL_TICKS) send_tick();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (40) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("preemptive_priority_scheduler verification clean");
    end else begin
      $display("preemptive_priority_scheduler verification failed");
    end
    $finish;
  end

endmodule
